FILE: rtl/potfs_pkg.sv
// Shared types, codes and defaults for the page owner table with fault swap.
package potfs_pkg;

  localparam int FRAMES_DEF     = 64;
  localparam int SWAP_SLOTS_DEF = 128;
  localparam int OWNER_BITS_DEF = 8;

  localparam int OP_W     = 2;
  localparam int THREAD_W = 8;
  localparam int VPAGE_W  = 6;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 7;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [THREAD_W-1:0] thread_id;
    logic [VPAGE_W-1:0]  page_index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
  } res_t;

  typedef enum logic [OP_W-1:0] {
    OP_FAULT   = 2'd0,
    OP_CLAIM   = 2'd1,
    OP_RELEASE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_HIT         = 3'd0,
    STAT_SWAP_FRAME  = 3'd1,
    STAT_SWAP_SLOT   = 3'd2,
    STAT_FAULT       = 3'd3,
    STAT_CLAIM_FRAME = 3'd4,
    STAT_CLAIM_SLOT  = 3'd5,
    STAT_FULL        = 3'd6,
    STAT_RELEASED    = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_HOME_RD,
    S_HOME_CHK,
    S_SCAN_F,
    S_SCAN_S,
    S_ACT_A,
    S_ACT_B,
    S_CLAIM_WR,
    S_RESP
  } state_t;

  typedef enum logic {
    TBL_FRAME,
    TBL_SLOT
  } tbl_t;

  typedef enum logic [1:0] {
    MODE_MATCH,
    MODE_FREE,
    MODE_OWNER
  } mode_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR_CNT,
    WR_CLEAR_CHK,
    WR_HOME_AT_CHK,
    WR_REQ_AT_CHK,
    WR_REQ_AT_PAGE
  } wr_t;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_PAGE,
    SEL_CHK
  } slot_sel_t;

  typedef struct packed {
    logic      req_load;
    logic      rd_home;
    logic      home_load;
    logic      cnt_clr;
    logic      step;
    logic      clr_step;
    tbl_t      rd_tbl;
    mode_t     mode;
    wr_t       wr_sel;
    logic      res_load;
    status_t   res_status;
    slot_sel_t slot_sel;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            tid_zero;
    logic            page_bad;
    logic            home_match;
    logic            hit;
    logic            chk_v;
    tbl_t            chk_tbl;
    logic            issue_end;
    logic            clear_last;
    logic            out_busy;
  } sts_t;

endpackage

FILE: rtl/potfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module potfs_ram #(
  parameter int W     = 14,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [W-1:0]                           wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                           rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/potfs_dp.sv
// Datapath: request latch, scan counter, owner tables, compare stage and result register.
module potfs_dp #(
  parameter int FRAMES     = potfs_pkg::FRAMES_DEF,
  parameter int SWAP_SLOTS = potfs_pkg::SWAP_SLOTS_DEF,
  parameter int OWNER_BITS = potfs_pkg::OWNER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  potfs_pkg::req_t   in_data,
  input  logic              out_ready,
  output logic              out_valid,
  output potfs_pkg::res_t   out_data,
  input  potfs_pkg::cmd_t   cmd,
  output potfs_pkg::sts_t   sts
);

  localparam int FIDX = $clog2(FRAMES);
  localparam int SIDX = (SWAP_SLOTS > 1) ? $clog2(SWAP_SLOTS) : 1;
  localparam int MAXN = (FRAMES > SWAP_SLOTS) ? FRAMES : SWAP_SLOTS;
  localparam int CW   = $clog2(MAXN + 1);
  localparam int VW   = potfs_pkg::VPAGE_W;
  localparam int EW   = OWNER_BITS + VW;

  potfs_pkg::req_t       req_r;
  logic [EW-1:0]         home_r;
  logic [CW-1:0]         cnt_r;
  logic [CW-1:0]         cnt_nxt;
  logic                  chk_v_r;
  logic [CW-1:0]         chk_idx_r;
  potfs_pkg::tbl_t       chk_tbl_r;
  logic                  out_valid_r;
  potfs_pkg::res_t       out_data_r;

  logic [OWNER_BITS-1:0] tid;
  logic [EW-1:0]         req_entry;
  logic [FIDX-1:0]       page_fidx;
  logic                  issue_end;
  logic                  issue;

  logic                  f_we;
  logic [FIDX-1:0]       f_wa;
  logic [EW-1:0]         f_wd;
  logic                  f_re;
  logic [FIDX-1:0]       f_ra;
  logic [EW-1:0]         f_rd;
  logic                  s_we;
  logic [SIDX-1:0]       s_wa;
  logic [EW-1:0]         s_wd;
  logic                  s_re;
  logic [EW-1:0]         s_rd;

  logic [EW-1:0]         chk_data;
  logic [OWNER_BITS-1:0] chk_owner;
  logic [VW-1:0]         chk_vpage;
  logic                  cond;
  logic                  hit;
  logic                  chk_we;
  logic [EW-1:0]         chk_wd;
  logic [potfs_pkg::SLOT_W-1:0] slot_val;

  assign tid       = OWNER_BITS'(req_r.thread_id);
  assign req_entry = {tid, req_r.page_index};
  assign page_fidx = FIDX'(req_r.page_index);

  assign issue_end = (cmd.rd_tbl == potfs_pkg::TBL_FRAME) ? (cnt_r >= CW'(FRAMES))
                                                          : (cnt_r >= CW'(SWAP_SLOTS));
  assign issue     = cmd.step & ~issue_end;

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (issue || cmd.clr_step) begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      chk_v_r <= issue;
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_r <= in_data;
    end
    if (cmd.home_load) begin
      home_r <= f_rd;
    end
    if (cmd.step) begin
      chk_idx_r <= cnt_r;
      chk_tbl_r <= cmd.rd_tbl;
    end
    if (cmd.res_load) begin
      out_data_r.status <= cmd.res_status;
      out_data_r.slot   <= slot_val;
    end
  end

  always_comb begin
    case (cmd.slot_sel)
      potfs_pkg::SEL_PAGE: slot_val = potfs_pkg::SLOT_W'(req_r.page_index);
      potfs_pkg::SEL_CHK:  slot_val = potfs_pkg::SLOT_W'(chk_idx_r);
      default:             slot_val = '0;
    endcase
  end

  // compare stage
  assign chk_data  = (chk_tbl_r == potfs_pkg::TBL_FRAME) ? f_rd : s_rd;
  assign chk_owner = chk_data[EW-1:VW];
  assign chk_vpage = chk_data[VW-1:0];

  always_comb begin
    case (cmd.mode)
      potfs_pkg::MODE_FREE:  cond = (chk_owner == '0);
      potfs_pkg::MODE_OWNER: cond = (chk_owner == tid);
      default:               cond = (chk_owner == tid) && (chk_vpage == req_r.page_index);
    endcase
  end

  assign hit = chk_v_r & cond;

  // table writes
  assign chk_we = (cmd.wr_sel != potfs_pkg::WR_CLEAR_CHK) || hit;

  always_comb begin
    case (cmd.wr_sel)
      potfs_pkg::WR_HOME_AT_CHK: chk_wd = home_r;
      potfs_pkg::WR_REQ_AT_CHK:  chk_wd = req_entry;
      default:                   chk_wd = '0;
    endcase
  end

  always_comb begin
    f_we = 1'b0;
    f_wa = cnt_r[FIDX-1:0];
    f_wd = '0;
    s_we = 1'b0;
    s_wa = cnt_r[SIDX-1:0];
    s_wd = '0;
    case (cmd.wr_sel)
      potfs_pkg::WR_CLEAR_CNT: begin
        f_we = (cnt_r < CW'(FRAMES));
        s_we = (cnt_r < CW'(SWAP_SLOTS));
      end
      potfs_pkg::WR_CLEAR_CHK, potfs_pkg::WR_HOME_AT_CHK, potfs_pkg::WR_REQ_AT_CHK: begin
        f_wa = chk_idx_r[FIDX-1:0];
        s_wa = chk_idx_r[SIDX-1:0];
        f_wd = chk_wd;
        s_wd = chk_wd;
        f_we = chk_we && (chk_tbl_r == potfs_pkg::TBL_FRAME);
        s_we = chk_we && (chk_tbl_r == potfs_pkg::TBL_SLOT);
      end
      potfs_pkg::WR_REQ_AT_PAGE: begin
        f_we = 1'b1;
        f_wa = page_fidx;
        f_wd = req_entry;
      end
      default: begin
      end
    endcase
  end

  assign f_re = cmd.rd_home | (issue && (cmd.rd_tbl == potfs_pkg::TBL_FRAME));
  assign f_ra = cmd.rd_home ? page_fidx : cnt_r[FIDX-1:0];
  assign s_re = issue && (cmd.rd_tbl == potfs_pkg::TBL_SLOT);

  potfs_ram #(
    .W     (EW),
    .DEPTH (FRAMES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_wa),
    .wdata (f_wd),
    .re    (f_re),
    .raddr (f_ra),
    .rdata (f_rd)
  );

  potfs_ram #(
    .W     (EW),
    .DEPTH (SWAP_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_wa),
    .wdata (s_wd),
    .re    (s_re),
    .raddr (cnt_r[SIDX-1:0]),
    .rdata (s_rd)
  );

  assign sts.op         = req_r.op;
  assign sts.tid_zero   = (tid == '0);
  assign sts.page_bad   = (32'(req_r.page_index) >= 32'(FRAMES));
  assign sts.home_match = (f_rd[EW-1:VW] == tid) && (f_rd[VW-1:0] == req_r.page_index);
  assign sts.hit        = hit;
  assign sts.chk_v      = chk_v_r;
  assign sts.chk_tbl    = chk_tbl_r;
  assign sts.issue_end  = issue_end;
  assign sts.clear_last = (cnt_r == CW'(MAXN - 1));
  assign sts.out_busy   = out_valid_r & ~out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/potfs_ctrl.sv
// Controller: sequences clearing, home check, table scans, swap writes and result hand-off.
module potfs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  potfs_pkg::sts_t sts,
  output potfs_pkg::cmd_t cmd
);

  potfs_pkg::state_t    state_r, state_nxt;
  potfs_pkg::status_t   res_r, res_nxt;
  potfs_pkg::slot_sel_t sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= potfs_pkg::S_CLEAR;
      res_r   <= potfs_pkg::STAT_FAULT;
      sel_r   <= potfs_pkg::SEL_ZERO;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    res_nxt        = res_r;
    sel_nxt        = sel_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.rd_tbl     = potfs_pkg::TBL_FRAME;
    cmd.mode       = potfs_pkg::MODE_MATCH;
    cmd.wr_sel     = potfs_pkg::WR_NONE;
    cmd.res_status = res_r;
    cmd.slot_sel   = sel_r;

    case (sts.op)
      potfs_pkg::OP_CLAIM:   cmd.mode = potfs_pkg::MODE_FREE;
      potfs_pkg::OP_RELEASE: cmd.mode = potfs_pkg::MODE_OWNER;
      default:               cmd.mode = potfs_pkg::MODE_MATCH;
    endcase

    case (state_r)
      potfs_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        cmd.wr_sel   = potfs_pkg::WR_CLEAR_CNT;
        if (sts.clear_last) begin
          state_nxt = potfs_pkg::S_IDLE;
        end
      end
      potfs_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        cmd.req_load = in_valid;
        if (in_valid) begin
          state_nxt = potfs_pkg::S_DECODE;
        end
      end
      potfs_pkg::S_DECODE: begin
        res_nxt   = potfs_pkg::STAT_FAULT;
        sel_nxt   = potfs_pkg::SEL_ZERO;
        state_nxt = potfs_pkg::S_RESP;
        case (sts.op)
          potfs_pkg::OP_FAULT: begin
            if (!sts.tid_zero && !sts.page_bad) begin
              state_nxt = potfs_pkg::S_HOME_RD;
            end
          end
          potfs_pkg::OP_CLAIM: begin
            if (!sts.tid_zero) begin
              cmd.cnt_clr = 1'b1;
              state_nxt   = potfs_pkg::S_SCAN_F;
            end
          end
          potfs_pkg::OP_RELEASE: begin
            res_nxt = potfs_pkg::STAT_RELEASED;
            if (!sts.tid_zero) begin
              cmd.cnt_clr = 1'b1;
              state_nxt   = potfs_pkg::S_SCAN_F;
            end
          end
          default: begin
          end
        endcase
      end
      potfs_pkg::S_HOME_RD: begin
        cmd.rd_home = 1'b1;
        state_nxt   = potfs_pkg::S_HOME_CHK;
      end
      potfs_pkg::S_HOME_CHK: begin
        cmd.home_load = 1'b1;
        if (sts.home_match) begin
          res_nxt   = potfs_pkg::STAT_HIT;
          sel_nxt   = potfs_pkg::SEL_PAGE;
          state_nxt = potfs_pkg::S_RESP;
        end else begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = potfs_pkg::S_SCAN_F;
        end
      end
      potfs_pkg::S_SCAN_F, potfs_pkg::S_SCAN_S: begin
        cmd.rd_tbl = (state_r == potfs_pkg::S_SCAN_F) ? potfs_pkg::TBL_FRAME
                                                       : potfs_pkg::TBL_SLOT;
        if (sts.op == potfs_pkg::OP_RELEASE) begin
          cmd.wr_sel = potfs_pkg::WR_CLEAR_CHK;
        end
        if (sts.hit && (sts.op != potfs_pkg::OP_RELEASE)) begin
          sel_nxt = potfs_pkg::SEL_CHK;
          if (sts.op == potfs_pkg::OP_CLAIM) begin
            res_nxt   = (sts.chk_tbl == potfs_pkg::TBL_FRAME) ? potfs_pkg::STAT_CLAIM_FRAME
                                                              : potfs_pkg::STAT_CLAIM_SLOT;
            state_nxt = potfs_pkg::S_CLAIM_WR;
          end else begin
            res_nxt   = (sts.chk_tbl == potfs_pkg::TBL_FRAME) ? potfs_pkg::STAT_SWAP_FRAME
                                                              : potfs_pkg::STAT_SWAP_SLOT;
            state_nxt = potfs_pkg::S_ACT_A;
          end
        end else if (sts.issue_end && !sts.chk_v) begin
          if (state_r == potfs_pkg::S_SCAN_F) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = potfs_pkg::S_SCAN_S;
          end else begin
            sel_nxt   = potfs_pkg::SEL_ZERO;
            state_nxt = potfs_pkg::S_RESP;
            case (sts.op)
              potfs_pkg::OP_CLAIM:   res_nxt = potfs_pkg::STAT_FULL;
              potfs_pkg::OP_RELEASE: res_nxt = potfs_pkg::STAT_RELEASED;
              default:               res_nxt = potfs_pkg::STAT_FAULT;
            endcase
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      potfs_pkg::S_ACT_A: begin
        cmd.wr_sel = potfs_pkg::WR_HOME_AT_CHK;
        state_nxt  = potfs_pkg::S_ACT_B;
      end
      potfs_pkg::S_ACT_B: begin
        cmd.wr_sel = potfs_pkg::WR_REQ_AT_PAGE;
        state_nxt  = potfs_pkg::S_RESP;
      end
      potfs_pkg::S_CLAIM_WR: begin
        cmd.wr_sel = potfs_pkg::WR_REQ_AT_CHK;
        state_nxt  = potfs_pkg::S_RESP;
      end
      potfs_pkg::S_RESP: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1;
          state_nxt    = potfs_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = potfs_pkg::S_IDLE;
      end
    endcase
  end

  a_accept_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == potfs_pkg::S_DECODE))
    else $error("accepted request did not enter decode");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> !sts.out_busy)
    else $error("result loaded while previous result still held");

  a_home_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == potfs_pkg::S_HOME_CHK) |-> ($past(state_r) == potfs_pkg::S_HOME_RD))
    else $error("home check without preceding home read");

  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == potfs_pkg::S_CLEAR && sts.clear_last) |=> (state_r == potfs_pkg::S_IDLE))
    else $error("clearing pass did not finish");

endmodule

FILE: rtl/page_owner_table_fault_swap.sv
// Top level of the page owner table with fault swap.
// After reset the block clears both owner tables, one entry of each per cycle, with
// in_ready low. A request is decided without a scan on a fault hit, a bad thread, a bad
// page or an unknown op, and scans otherwise: each table has one read port and the scan
// reads one entry per cycle, frames first, then swap slots. A release with a nonzero
// thread always scans both tables. A result held in the output register by out_ready
// low keeps the next result waiting in S_RESP until it is taken. One request is in
// flight at a time; the next one is taken as soon as its result sits in the output
// register.
module page_owner_table_fault_swap #(
  parameter int FRAMES     = potfs_pkg::FRAMES_DEF,
  parameter int SWAP_SLOTS = potfs_pkg::SWAP_SLOTS_DEF,
  parameter int OWNER_BITS = potfs_pkg::OWNER_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  potfs_pkg::req_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output potfs_pkg::res_t out_data
);

  potfs_pkg::cmd_t cmd;
  potfs_pkg::sts_t sts;

  potfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  potfs_dp #(
    .FRAMES     (FRAMES),
    .SWAP_SLOTS (SWAP_SLOTS),
    .OWNER_BITS (OWNER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

FILE: tb/tb_page_owner_table_fault_swap.sv
// Self-checking testbench for the page owner table with fault swap.
`timescale 1ns / 100ps

module tb_page_owner_table_fault_swap;

  localparam int NFR   = potfs_pkg::FRAMES_DEF;
  localparam int NSL   = potfs_pkg::SWAP_SLOTS_DEF;
  localparam int OWN_W = potfs_pkg::OWNER_BITS_DEF;

  localparam logic [potfs_pkg::OP_W-1:0] OP_UNKNOWN = 2'd3;

  localparam longint LIMIT_NS = 64'd20_000_000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  potfs_pkg::req_t in_data;
  logic out_valid;
  logic out_ready;
  potfs_pkg::res_t out_data;

  bit quiet;
  int stall_cycles;
  potfs_pkg::req_t claim_hist[$];

  class owner_table_tracker;
    logic [OWN_W-1:0]              frame_owner [NFR];
    logic [potfs_pkg::VPAGE_W-1:0] frame_vpage [NFR];
    logic [OWN_W-1:0]              slot_owner [NSL];
    logic [potfs_pkg::VPAGE_W-1:0] slot_vpage [NSL];
    potfs_pkg::res_t expected_res[$];
    int errors;

    function new();
      int i;
      for (i = 0; i < NFR; i++) begin
        frame_owner[i] = '0;
        frame_vpage[i] = '0;
      end
      for (i = 0; i < NSL; i++) begin
        slot_owner[i] = '0;
        slot_vpage[i] = '0;
      end
      errors = 0;
    endfunction

    function int pending();
      return expected_res.size();
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Work out the response to an accepted request and update the tables.
    function void note_request(potfs_pkg::req_t r);
      logic [OWN_W-1:0]              tid;
      logic [potfs_pkg::VPAGE_W-1:0] pg;
      potfs_pkg::res_t e;
      bit found;
      int i;
      tid = r.thread_id[OWN_W-1:0];
      pg = r.page_index;
      e.status = potfs_pkg::STAT_FAULT;
      e.slot = '0;
      found = 0;
      case (r.op)
        potfs_pkg::OP_FAULT: begin
          if (tid != '0 && int'(pg) < NFR) begin
            if (frame_owner[pg] == tid && frame_vpage[pg] == pg) begin
              e.status = potfs_pkg::STAT_HIT;
              e.slot = potfs_pkg::SLOT_W'(pg);
            end else begin
              for (i = 0; i < NFR && !found; i++) begin
                if (frame_owner[i] == tid && frame_vpage[i] == pg) begin
                  found = 1;
                  frame_owner[i] = frame_owner[pg];
                  frame_vpage[i] = frame_vpage[pg];
                  frame_owner[pg] = tid;
                  frame_vpage[pg] = pg;
                  e.status = potfs_pkg::STAT_SWAP_FRAME;
                  e.slot = i[potfs_pkg::SLOT_W-1:0];
                end
              end
              for (i = 0; i < NSL && !found; i++) begin
                if (slot_owner[i] == tid && slot_vpage[i] == pg) begin
                  found = 1;
                  slot_owner[i] = frame_owner[pg];
                  slot_vpage[i] = frame_vpage[pg];
                  frame_owner[pg] = tid;
                  frame_vpage[pg] = pg;
                  e.status = potfs_pkg::STAT_SWAP_SLOT;
                  e.slot = i[potfs_pkg::SLOT_W-1:0];
                end
              end
            end
          end
        end
        potfs_pkg::OP_CLAIM: begin
          if (tid != '0) begin
            e.status = potfs_pkg::STAT_FULL;
            for (i = 0; i < NFR && !found; i++) begin
              if (frame_owner[i] == '0) begin
                found = 1;
                frame_owner[i] = tid;
                frame_vpage[i] = pg;
                e.status = potfs_pkg::STAT_CLAIM_FRAME;
                e.slot = i[potfs_pkg::SLOT_W-1:0];
              end
            end
            for (i = 0; i < NSL && !found; i++) begin
              if (slot_owner[i] == '0) begin
                found = 1;
                slot_owner[i] = tid;
                slot_vpage[i] = pg;
                e.status = potfs_pkg::STAT_CLAIM_SLOT;
                e.slot = i[potfs_pkg::SLOT_W-1:0];
              end
            end
          end
        end
        potfs_pkg::OP_RELEASE: begin
          if (tid != '0) begin
            for (i = 0; i < NFR; i++) begin
              if (frame_owner[i] == tid) begin
                frame_owner[i] = '0;
                frame_vpage[i] = '0;
              end
            end
            for (i = 0; i < NSL; i++) begin
              if (slot_owner[i] == tid) begin
                slot_owner[i] = '0;
                slot_vpage[i] = '0;
              end
            end
          end
          e.status = potfs_pkg::STAT_RELEASED;
        end
        default: ;
      endcase
      expected_res.push_back(e);
    endfunction

    task check_result(potfs_pkg::res_t got);
      potfs_pkg::res_t e;
      if (expected_res.size() == 0) begin
        report($sformatf("unexpected response status=%0d slot=%0d", got.status, got.slot));
        return;
      end
      e = expected_res.pop_front();
      if (got.status !== e.status)
        report($sformatf("status %0d, expected %0d", got.status, e.status));
      if (got.slot !== e.slot)
        report($sformatf("slot %0d, expected %0d", got.slot, e.slot));
    endtask
  endclass

  owner_table_tracker tracker = new();

  page_owner_table_fault_swap dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic potfs_pkg::req_t mk(logic [potfs_pkg::OP_W-1:0] op, int tid, int pg);
    potfs_pkg::req_t q;
    q.op = op;
    q.thread_id = tid[potfs_pkg::THREAD_W-1:0];
    q.page_index = pg[potfs_pkg::VPAGE_W-1:0];
    return q;
  endfunction

  // Mostly a handful of threads; faults usually revisit a recently claimed page.
  function automatic potfs_pkg::req_t random_request(int rel_pct);
    int r;
    int tid;
    int pg;
    logic [potfs_pkg::OP_W-1:0] op;
    potfs_pkg::req_t q;
    r = int'($urandom_range(0, 99));
    if (r < rel_pct) op = potfs_pkg::OP_RELEASE;
    else if (r < rel_pct + 2) op = OP_UNKNOWN;
    else if (r < rel_pct + 47) op = potfs_pkg::OP_CLAIM;
    else op = potfs_pkg::OP_FAULT;
    r = int'($urandom_range(0, 99));
    if (r < 85) tid = int'($urandom_range(1, 6));
    else if (r < 96) tid = int'($urandom_range(0, 255));
    else tid = 0;
    pg = int'($urandom_range(0, 63));
    if (op == potfs_pkg::OP_FAULT && claim_hist.size() != 0 && $urandom_range(0, 9) < 7) begin
      q = claim_hist[$urandom_range(0, claim_hist.size() - 1)];
      tid = int'(q.thread_id);
      pg = int'(q.page_index);
    end
    q = mk(op, tid, pg);
    if (op == potfs_pkg::OP_CLAIM) begin
      claim_hist.push_back(q);
      if (claim_hist.size() > 64) void'(claim_hist.pop_front());
    end
    return q;
  endfunction

  task automatic send_request(potfs_pkg::req_t r);
    int gap;
    in_data <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    tracker.note_request(r);
    gap = quiet ? 0 : int'($urandom_range(0, 4));
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Response side: random hold-offs, plus the occasional long stall.
  initial begin
    int gap;
    out_ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = quiet ? 0 : int'($urandom_range(0, 4));
      if (stall_cycles != 0) begin
        gap = stall_cycles;
        stall_cycles = 0;
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      tracker.check_result(out_data);
    end
  end

  initial begin
    int seg;
    int n;
    int rel_pct;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    quiet = 1'b0;
    stall_cycles = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // no current thread, unknown op, empty tables
    send_request(mk(potfs_pkg::OP_FAULT, 0, 0));
    send_request(mk(potfs_pkg::OP_CLAIM, 0, 63));
    send_request(mk(potfs_pkg::OP_RELEASE, 0, 0));
    send_request(mk(OP_UNKNOWN, 5, 7));
    send_request(mk(potfs_pkg::OP_FAULT, 1, 5));
    // hit, swap between frames, reuse of a freed frame
    send_request(mk(potfs_pkg::OP_CLAIM, 1, 0));
    send_request(mk(potfs_pkg::OP_FAULT, 1, 0));
    send_request(mk(potfs_pkg::OP_CLAIM, 1, 63));
    send_request(mk(potfs_pkg::OP_FAULT, 1, 63));
    send_request(mk(potfs_pkg::OP_FAULT, 1, 63));
    send_request(mk(potfs_pkg::OP_CLAIM, 255, 63));
    send_request(mk(potfs_pkg::OP_FAULT, 255, 63));
    send_request(mk(potfs_pkg::OP_FAULT, 255, 63));
    send_request(mk(potfs_pkg::OP_RELEASE, 255, 0));
    send_request(mk(potfs_pkg::OP_FAULT, 255, 63));
    send_request(mk(potfs_pkg::OP_CLAIM, 8'hAA, 6'h2A));
    send_request(mk(potfs_pkg::OP_CLAIM, 8'h55, 6'h15));
    send_request(mk(potfs_pkg::OP_FAULT, 8'h55, 6'h15));
    send_request(mk(potfs_pkg::OP_FAULT, 8'hAA, 6'h2A));
    send_request(mk(OP_UNKNOWN, 255, 63));
    send_request(mk(potfs_pkg::OP_RELEASE, 1, 63));
    send_request(mk(potfs_pkg::OP_RELEASE, 8'hAA, 0));

    // first segments fill both tables, later ones churn
    for (seg = 0; seg < 19; seg++) begin
      if (seg < 5) rel_pct = 0;
      else if ($urandom_range(0, 3) == 0) rel_pct = 0;
      else rel_pct = int'($urandom_range(1, 6));
      quiet = ($urandom_range(0, 3) == 0);
      for (n = 0; n < 100; n++) begin
        if (seg * 100 + n == 500 || seg * 100 + n == 1300) stall_cycles = 400;
        send_request(random_request(rel_pct));
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (NFR + NSL + 16) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
rtl/potfs_pkg.sv
rtl/potfs_ram.sv
rtl/potfs_dp.sv
rtl/potfs_ctrl.sv
rtl/page_owner_table_fault_swap.sv
tb/tb_page_owner_table_fault_swap.sv
